FILE: hdl/tfrm_pkg.sv
// tfrm_pkg: shared types and constants of the frame run monitor
// no dependencies; imported by the parser, the run accumulator and the top level
`timescale 1ns / 1ps
`default_nettype none

package tfrm_pkg;

  // largest content size a frame can carry (width of the remaining counter)
  localparam logic [30:0] CONTENT_MAX = 31'h7FFF_FFFF;

  // parser phase per stream; the unused code behaves as the type phase
  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_CONTENT = 2'd2
  } phase_e;

  // frame end event from the parser to the run accumulator
  typedef struct packed {
    logic        dir;
    logic [7:0]  ftype;
    logic [30:0] content;
    logic        short_len;
  } frame_evt_t;

  // report of a finished run
  typedef struct packed {
    logic        dir;
    logic [7:0]  run_type;
    logic [31:0] run_count;
    logic [31:0] run_bytes;
    logic        short_seen;
  } run_report_t;

endpackage

`default_nettype wire

FILE: hdl/tfrm_if.sv
// tfrm_in_if / tfrm_out_if: valid-ready channels of the frame run monitor
// no dependencies; used by the top level ports
`timescale 1ns / 1ps
`default_nettype none

// byte beats of the observed streams
interface tfrm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       direction;

  modport source (output valid, output data_byte, output direction, input ready);
  modport sink   (input valid, input data_byte, input direction, output ready);
endinterface

// run report beats
interface tfrm_out_if;
  logic        valid;
  logic        ready;
  logic        report_direction;
  logic [7:0]  run_type;
  logic [31:0] run_count;
  logic [31:0] run_bytes;
  logic        short_length_seen;

  modport source (output valid, output report_direction, output run_type,
                  output run_count, output run_bytes, output short_length_seen,
                  input ready);
  modport sink   (input valid, input report_direction, input run_type,
                  input run_count, input run_bytes, input short_length_seen,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/tlv_frame_run_monitor.sv
// channel  dir  handshake    payload
// in_i     in   valid/ready  data_byte[7:0], direction
// out_o    out  valid/ready  report_direction, run_type[7:0], run_count[31:0],
//                            run_bytes[31:0], short_length_seen
//
// one byte beat per cycle is taken while input is not stalled; the beat that ends
// a frame passes the input register, parser stage and run record stage before a report leaves
// each stage holds its item only while the stage after it is full and stalled,
// so input stalls only when the report register and both inner stages are full
// rst_ni clears parser phases, run records and all valid bits at once
//
// top level of the frame run monitor; depends on tfrm_pkg, tfrm_if,
// tfrm_parser and tfrm_run_acc
`timescale 1ns / 1ps
`default_nettype none

module tlv_frame_run_monitor
  import tfrm_pkg::*;
#(
  parameter int LENGTH_BYTES = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tfrm_in_if.sink    in_i,
  tfrm_out_if.source out_o
);

  logic        ev_valid;
  logic        ev_ready;
  frame_evt_t  ev;
  run_report_t rep;

  // frame parser
  tfrm_parser #(
    .LENGTH_BYTES(LENGTH_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .in_byte_i (in_i.data_byte),
    .in_dir_i  (in_i.direction),
    .ev_valid_o(ev_valid),
    .ev_ready_i(ev_ready),
    .ev_o      (ev)
  );

  // run accumulation and reports
  tfrm_run_acc u_run_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_valid_i (ev_valid),
    .ev_ready_o (ev_ready),
    .ev_i       (ev),
    .rep_valid_o(out_o.valid),
    .rep_ready_i(out_o.ready),
    .rep_o      (rep)
  );

  assign out_o.report_direction  = rep.dir;
  assign out_o.run_type          = rep.run_type;
  assign out_o.run_count         = rep.run_count;
  assign out_o.run_bytes         = rep.run_bytes;
  assign out_o.short_length_seen = rep.short_seen;

`ifndef ASSERT_OFF
  // input stalls only when the whole pipe is backed up to a waiting report
  a_stall_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without a blocked report");

  // only the reset run can have no frames
  a_empty_run_is_reset_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.run_count == 32'd0) |->
      (out_o.run_type == 8'd0 && out_o.run_bytes == 32'd0 && !out_o.short_length_seen))
    else $error("empty run report with nonzero contents");

  // a single frame carries at most the content maximum
  a_single_frame_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.run_count == 32'd1) |-> !out_o.run_bytes[31])
    else $error("single frame run exceeds content maximum");
`endif

endmodule

`default_nettype wire

FILE: hdl/tfrm_parser.sv
// tfrm_parser: input register and per-stream type/length/content parser
// depends on tfrm_pkg; emits one frame end event per completed frame
`timescale 1ns / 1ps
`default_nettype none

module tfrm_parser
  import tfrm_pkg::*;
#(
  parameter int LENGTH_BYTES = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_dir_i,
  output logic            ev_valid_o,
  input  wire logic       ev_ready_i,
  output frame_evt_t      ev_o
);

  localparam logic [2:0]  LB_IDX = 3'(LENGTH_BYTES);
  localparam logic [32:0] LB_LEN = 33'(LENGTH_BYTES);

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_dir_q;

  // per-stream parser state
  phase_e      phase_q [2];
  logic [7:0]  ftype_q [2];
  logic [2:0]  idx_q   [2];
  logic [31:0] asm_q   [2];
  logic [30:0] rem_q   [2];

  phase_e      phase_d;
  logic [7:0]  ftype_d;
  logic [2:0]  idx_d;
  logic [31:0] asm_d;
  logic [30:0] rem_d;

  logic        ev_valid_q;
  frame_evt_t  ev_q;
  logic        fin;
  logic [30:0] fin_content;
  logic        fin_short;

  logic ev_move;
  logic s1_move;
  logic step;

  logic [31:0] asm_shift;
  logic [2:0]  idx_inc;
  logic [32:0] diff;
  logic [30:0] content;
  logic [30:0] rem_dec;

  assign ev_move    = !ev_valid_q || ev_ready_i;
  assign s1_move    = !s1_valid_q || ev_move;
  assign step       = s1_valid_q && ev_move;
  assign in_ready_o = s1_move;

  // input beat capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_move) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && in_valid_i) begin
      s1_byte_q <= in_byte_i;
      s1_dir_q  <= in_dir_i;
    end
  end

  // datapath helpers for the selected stream
  assign asm_shift = {asm_q[s1_dir_q][23:0], s1_byte_q};
  assign idx_inc   = idx_q[s1_dir_q] + 3'd1;
  assign diff      = {1'b0, asm_shift} - LB_LEN;
  assign content   = diff[31] ? CONTENT_MAX : diff[30:0];
  assign rem_dec   = rem_q[s1_dir_q] - 31'd1;

  // next parser state of the selected stream
  always_comb begin
    phase_d     = phase_q[s1_dir_q];
    ftype_d     = ftype_q[s1_dir_q];
    idx_d       = idx_q[s1_dir_q];
    asm_d       = asm_q[s1_dir_q];
    rem_d       = rem_q[s1_dir_q];
    fin         = 1'b0;
    fin_content = '0;
    fin_short   = 1'b0;
    unique case (phase_q[s1_dir_q])
      PH_LENGTH: begin
        asm_d = asm_shift;
        idx_d = idx_inc;
        if (idx_inc >= LB_IDX) begin
          if (diff[32]) begin
            fin       = 1'b1;
            fin_short = 1'b1;
          end else if (content == '0) begin
            fin = 1'b1;
          end else begin
            rem_d   = content;
            asm_d   = {1'b0, content};
            phase_d = PH_CONTENT;
          end
        end
      end
      PH_CONTENT: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          fin         = 1'b1;
          fin_content = asm_q[s1_dir_q][30:0];
        end
      end
      default: begin
        ftype_d = s1_byte_q;
        idx_d   = '0;
        asm_d   = '0;
        rem_d   = '0;
        phase_d = PH_LENGTH;
      end
    endcase
    // frame end clears the parser
    if (fin) begin
      phase_d = PH_TYPE;
      idx_d   = '0;
      asm_d   = '0;
      rem_d   = '0;
    end
  end

  // per-stream state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        phase_q[i] <= PH_TYPE;
        ftype_q[i] <= '0;
        idx_q[i]   <= '0;
        asm_q[i]   <= '0;
        rem_q[i]   <= '0;
      end
    end else if (step) begin
      phase_q[s1_dir_q] <= phase_d;
      ftype_q[s1_dir_q] <= ftype_d;
      idx_q[s1_dir_q]   <= idx_d;
      asm_q[s1_dir_q]   <= asm_d;
      rem_q[s1_dir_q]   <= rem_d;
    end
  end

  // frame end event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (ev_move) begin
      ev_valid_q <= step && fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && fin) begin
      ev_q.dir       <= s1_dir_q;
      ev_q.ftype     <= ftype_q[s1_dir_q];
      ev_q.content   <= fin_content;
      ev_q.short_len <= fin_short;
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

endmodule

`default_nettype wire

FILE: hdl/tfrm_run_acc.sv
// tfrm_run_acc: per-stream run records and the report output register
// depends on tfrm_pkg; consumes frame end events from tfrm_parser
`timescale 1ns / 1ps
`default_nettype none

module tfrm_run_acc
  import tfrm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       ev_valid_i,
  output logic            ev_ready_o,
  input  wire frame_evt_t ev_i,
  output logic            rep_valid_o,
  input  wire logic       rep_ready_i,
  output run_report_t     rep_o
);

  logic [7:0]  rtype_q  [2];
  logic [31:0] rcount_q [2];
  logic [31:0] rbytes_q [2];
  logic        rshort_q [2];

  logic        rep_valid_q;
  run_report_t rep_q;

  logic        out_move;
  logic        step;
  logic        same;
  logic [32:0] cnt_sum;
  logic [32:0] byte_sum;
  logic [31:0] cnt_sat;
  logic [31:0] byte_sat;

  assign out_move   = !rep_valid_q || rep_ready_i;
  assign step       = ev_valid_i && out_move;
  assign ev_ready_o = out_move;

  // saturating run totals
  assign same     = ev_i.ftype == rtype_q[ev_i.dir];
  assign cnt_sum  = {1'b0, rcount_q[ev_i.dir]} + 33'd1;
  assign byte_sum = {1'b0, rbytes_q[ev_i.dir]} + {2'b00, ev_i.content};
  assign cnt_sat  = cnt_sum[32] ? '1 : cnt_sum[31:0];
  assign byte_sat = byte_sum[32] ? '1 : byte_sum[31:0];

  // run records
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        rtype_q[i]  <= '0;
        rcount_q[i] <= '0;
        rbytes_q[i] <= '0;
        rshort_q[i] <= 1'b0;
      end
    end else if (step) begin
      if (same) begin
        rcount_q[ev_i.dir] <= cnt_sat;
        rbytes_q[ev_i.dir] <= byte_sat;
        rshort_q[ev_i.dir] <= rshort_q[ev_i.dir] | ev_i.short_len;
      end else begin
        rtype_q[ev_i.dir]  <= ev_i.ftype;
        rcount_q[ev_i.dir] <= 32'd1;
        rbytes_q[ev_i.dir] <= {1'b0, ev_i.content};
        rshort_q[ev_i.dir] <= ev_i.short_len;
      end
    end
  end

  // report output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_valid_q <= 1'b0;
    end else if (out_move) begin
      rep_valid_q <= step && !same;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && !same) begin
      rep_q.dir        <= ev_i.dir;
      rep_q.run_type   <= rtype_q[ev_i.dir];
      rep_q.run_count  <= rcount_q[ev_i.dir];
      rep_q.run_bytes  <= rbytes_q[ev_i.dir];
      rep_q.short_seen <= rshort_q[ev_i.dir];
    end
  end

  assign rep_valid_o = rep_valid_q;
  assign rep_o       = rep_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_tlv_frame_run_monitor.sv
// tb_tlv_frame_run_monitor: self-checking bench for the frame run monitor
// drives interleaved send/receive byte beats, tracks both parsers, checks run reports
// depends on tfrm_pkg, tfrm_if and tlv_frame_run_monitor
`timescale 1ns / 1ps

module tb_tlv_frame_run_monitor
  import tfrm_pkg::*;
();

  localparam int          LEN_BYTES     = 4;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tfrm_in_if  in_bus ();
  tfrm_out_if out_bus ();

  tlv_frame_run_monitor #(.LENGTH_BYTES(LEN_BYTES)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run control
  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_req;
  int          fail_count;
  int unsigned cycle_n = 0;

  // per stream parser and run record, tracked beat by beat
  phase_e      parse_ph   [2];
  logic [7:0]  cur_type   [2];
  logic [2:0]  len_idx    [2];
  logic [31:0] len_acc    [2];
  logic [30:0] body_left  [2];
  logic [7:0]  run_type_r [2];
  logic [31:0] run_count_r[2];
  logic [31:0] run_bytes_r[2];
  logic        run_short_r[2];
  run_report_t pending_reports[$];

  // bytes waiting to go out on each stream
  logic [7:0]  lane_q0[$];
  logic [7:0]  lane_q1[$];
  logic [7:0]  type_pool[3];

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // frame end: grow the run or report it and start a new one
  function automatic void close_frame(input int d, input logic [30:0] body,
                                      input logic short_len);
    run_report_t rep;
    if (cur_type[d] == run_type_r[d]) begin
      run_count_r[d] = sat_add32(run_count_r[d], 32'd1);
      run_bytes_r[d] = sat_add32(run_bytes_r[d], {1'b0, body});
      if (short_len) run_short_r[d] = 1'b1;
    end else begin
      rep.dir        = (d == 1);
      rep.run_type   = run_type_r[d];
      rep.run_count  = run_count_r[d];
      rep.run_bytes  = run_bytes_r[d];
      rep.short_seen = run_short_r[d];
      pending_reports.push_back(rep);
      run_type_r[d]  = cur_type[d];
      run_count_r[d] = 32'd1;
      run_bytes_r[d] = {1'b0, body};
      run_short_r[d] = short_len;
    end
    parse_ph[d]  = PH_TYPE;
    len_idx[d]   = 3'd0;
    len_acc[d]   = 32'd0;
    body_left[d] = 31'd0;
  endfunction

  // advance one stream by one accepted byte
  function automatic void track_beat(input logic [7:0] b, input logic dir);
    int          d;
    logic [31:0] body;
    d = dir ? 1 : 0;
    case (parse_ph[d])
      PH_LENGTH: begin
        len_acc[d] = {len_acc[d][23:0], b};
        len_idx[d] = len_idx[d] + 3'd1;
        if (int'(len_idx[d]) >= LEN_BYTES) begin
          if (len_acc[d] < 32'(LEN_BYTES)) begin
            close_frame(d, 31'd0, 1'b1);
          end else begin
            body = len_acc[d] - 32'(LEN_BYTES);
            if (body > {1'b0, CONTENT_MAX}) body = {1'b0, CONTENT_MAX};
            if (body == 32'd0) begin
              close_frame(d, 31'd0, 1'b0);
            end else begin
              body_left[d] = body[30:0];
              len_acc[d]   = body;
              parse_ph[d]  = PH_CONTENT;
            end
          end
        end
      end
      PH_CONTENT: begin
        body_left[d] = body_left[d] - 31'd1;
        if (body_left[d] == 31'd0) close_frame(d, len_acc[d][30:0], 1'b0);
      end
      default: begin
        cur_type[d]  = b;
        len_idx[d]   = 3'd0;
        len_acc[d]   = 32'd0;
        body_left[d] = 31'd0;
        parse_ph[d]  = PH_LENGTH;
      end
    endcase
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // one byte beat; returns at the edge that accepted it
  task automatic send_beat(input logic [7:0] b, input logic dir);
    int gap;
    gap = pick_gap(src_gaps);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.direction <= dir;
    forever begin
      @(negedge clk_i);
      if (in_bus.ready === 1'b1) break;
    end
    @(posedge clk_i);
    track_beat(b, dir);
  endtask

  // queue type, big-endian length and content bytes on one stream
  task automatic queue_frame(input logic dir, input logic [7:0] t,
                             input logic [31:0] len, input int n_body);
    logic [7:0] fb;
    for (int i = 0; i < 1 + LEN_BYTES + n_body; i++) begin
      if (i == 0) fb = t;
      else if (i <= LEN_BYTES) fb = len[8*(LEN_BYTES-i) +: 8];
      else fb = 8'($urandom_range(255));
      if (dir) lane_q1.push_back(fb);
      else lane_q0.push_back(fb);
    end
  endtask

  task automatic queue_random_frame(input logic dir);
    int          r;
    logic [31:0] len;
    logic [7:0]  t;
    r = $urandom_range(99);
    if (r < 10) len = $urandom_range(3, 0);
    else if (r < 22) len = 32'(LEN_BYTES);
    else if (r < 92) len = $urandom_range(20, 5);
    else len = $urandom_range(300, 21);
    // a small pool of types keeps runs going
    if ($urandom_range(99) < 75) t = type_pool[$urandom_range(2)];
    else t = 8'($urandom_range(255));
    queue_frame(dir, t, len, (len > 32'(LEN_BYTES)) ? int'(len) - LEN_BYTES : 0);
  endtask

  task automatic send_queued(input logic dir);
    if (dir) send_beat(lane_q1.pop_front(), 1'b1);
    else send_beat(lane_q0.pop_front(), 1'b0);
  endtask

  task automatic flush_lanes();
    while (lane_q0.size() != 0) send_queued(1'b0);
    while (lane_q1.size() != 0) send_queued(1'b1);
  endtask

  // sender pause until every pending report is out
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_report();
    run_report_t want;
    if (pending_reports.size() == 0) begin
      $error("report with none pending: dir %0d type %0d count %0d",
             out_bus.report_direction, out_bus.run_type, out_bus.run_count);
      fail_count++;
      return;
    end
    want = pending_reports.pop_front();
    check_field("report_direction", 32'(want.dir), 32'(out_bus.report_direction));
    check_field("run_type", 32'(want.run_type), 32'(out_bus.run_type));
    check_field("run_count", want.run_count, out_bus.run_count);
    check_field("run_bytes", want.run_bytes, out_bus.run_bytes);
    check_field("short_length_seen", 32'(want.short_seen), 32'(out_bus.short_length_seen));
  endtask

  // report side: check at the falling edge, pick ready at the rising edge
  initial begin : report_sink
    int stall_left;
    int hold_left;
    stall_left    = 0;
    hold_left     = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) check_report();
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_ni) begin
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if ($urandom_range(99) < 25) stall_left = pick_gap(sink_gaps);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // type zero joining the reset run, first reports, short and empty lengths
  task automatic test_directed_runs();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    queue_frame(1'b0, 8'h00, 32'd4, 0);
    queue_frame(1'b1, 8'hFF, 32'd0, 0);
    queue_frame(1'b0, 8'h00, 32'd3, 0);
    queue_frame(1'b0, 8'hA5, 32'd6, 2);
    queue_frame(1'b1, 8'hFF, 32'd1, 0);
    flush_lanes();
  endtask

  // interleaved frames on both streams, idling switched per stretch
  task automatic test_random_frames(input int n_items);
    logic dir;
    dir = 1'b0;
    for (int i = 0; i < 3; i++) type_pool[i] = 8'($urandom_range(255));
    for (int sent = 0; sent < n_items; sent++) begin
      if (sent % 100 == 0) begin
        src_gaps  = ($urandom_range(3) != 0);
        sink_gaps = ($urandom_range(3) != 0);
      end
      if ($urandom_range(99) < 30) dir = ~dir;
      if ((dir ? lane_q1.size() : lane_q0.size()) == 0) queue_random_frame(dir);
      send_queued(dir);
    end
    flush_lanes();
  endtask

  // report side held off while empty frames of alternating type keep coming
  task automatic test_back_pressure();
    src_gaps = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++)
      queue_frame(1'b0, i[0] ? 8'h11 : 8'h22, 32'(LEN_BYTES), 0);
    flush_lanes();
  endtask

  task automatic test_sender_pause();
    wait_drained();
    test_random_frames(300);
  endtask

  // content sizes at and past the counter width; these frames never end
  task automatic test_huge_lengths();
    src_gaps = 1'b1;
    queue_frame(1'b0, 8'h5A, 32'h8000_0004, 12);
    queue_frame(1'b1, 8'hC3, 32'hFFFF_FFFF, 12);
    flush_lanes();
  endtask

  initial begin
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= 8'h00;
    in_bus.direction <= 1'b0;
    fail_count       = 0;
    hold_req         = 1'b0;
    for (int d = 0; d < 2; d++) begin
      parse_ph[d]    = PH_TYPE;
      cur_type[d]    = 8'h00;
      len_idx[d]     = 3'd0;
      len_acc[d]     = 32'd0;
      body_left[d]   = 31'd0;
      run_type_r[d]  = 8'h00;
      run_count_r[d] = 32'd0;
      run_bytes_r[d] = 32'd0;
      run_short_r[d] = 1'b0;
    end

    // reset
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_runs();
    test_random_frames(700);
    test_sender_pause();
    test_back_pressure();
    test_random_frames(500);
    test_huge_lengths();
    wait_drained();

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
